[design/salru_pkg.sv]
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types, codes and defaults for the LRU cache hit/miss simulator.
// ----------------------------------------------------------------------------
package salru_pkg;

    // Default sizing
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    // Action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_STORE   = 2'd1;
    localparam logic [1:0] ACT_MODIFY  = 2'd2;
    localparam logic [1:0] ACT_UNDEF   = 2'd3;

    // Outcome codes
    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_FILL    = 2'd1;
    localparam logic [1:0] OUT_EVICT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_OFF_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS     = 2'd2;

    // Configuration reset values
    localparam logic [2:0] RST_SET_BITS = 3'd4;
    localparam logic [5:0] RST_OFF_BITS = 6'd4;
    localparam logic [3:0] RST_WAYS     = 4'd1;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Front-to-back request control
    typedef struct packed {
        logic valid;
        logic twice;
    } req_ctl_t;

    // One result word
    typedef struct packed {
        logic [1:0]  outcome;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } result_t;

endpackage

[design/salru_front.sv]
// ----------------------------------------------------------------------------
// salru_front
// Accepts input words, splits the address into set and tag, and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module salru_front #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          action,
    input  logic [63:0]         address,
    input  logic [2:0]          set_bits,
    input  logic [5:0]          off_bits,
    output salru_pkg::req_ctl_t req_ctl,
    output logic [SET_W-1:0]    req_set,
    output logic [63:0]         req_tag,
    input  logic                req_ready
);
    import salru_pkg::*;

    logic [2:0]       sbits_eff;
    logic [6:0]       tshift;
    logic [63:0]      shifted;
    logic [63:0]      set_mask;
    logic [SET_W-1:0] set_calc;
    logic [63:0]      tag_calc;

    logic [SET_W-1:0] set_q_reg [2];
    logic [63:0]      tag_q_reg [2];
    logic [1:0]       twice_q_reg;
    logic [1:0]       count_reg, count_next;
    logic             head_reg, tail_reg;
    logic             wr_en, rd_en;

    // Split the address into set and tag
    always_comb
    begin
        if (32'(set_bits) > MAX_SET_BITS)
            sbits_eff = 3'(MAX_SET_BITS);
        else
            sbits_eff = set_bits;
        shifted  = address >> off_bits;
        set_mask = (64'd1 << sbits_eff) - 64'd1;
        set_calc = SET_W'(shifted & set_mask);
        tshift   = 7'(off_bits) + 7'(sbits_eff);
        tag_calc = (tshift >= 7'd64) ? 64'd0 : (address >> tshift);
    end

    assign full  = (count_reg == 2'd2);
    assign wr_en = push && !full && (action != ACT_UNDEF);
    assign rd_en = (count_reg != 2'd0) && req_ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            set_q_reg[tail_reg]   <= set_calc;
            tag_q_reg[tail_reg]   <= tag_calc;
            twice_q_reg[tail_reg] <= (action == ACT_MODIFY);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                tail_reg <= ~tail_reg;
            if (rd_en)
                head_reg <= ~head_reg;
        end
    end

    assign req_ctl.valid = (count_reg != 2'd0);
    assign req_ctl.twice = twice_q_reg[head_reg];
    assign req_set       = set_q_reg[head_reg];
    assign req_tag       = tag_q_reg[head_reg];

endmodule

[design/salru_back.sv]
// ----------------------------------------------------------------------------
// salru_back
// Runs each access against the line memory: read the set row, compare all
// ways, pick hit, free way or LRU victim, write the row back and queue the result.
// ----------------------------------------------------------------------------
module salru_back #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  salru_pkg::req_ctl_t req_ctl,
    input  logic [SET_W-1:0]    req_set,
    input  logic [63:0]         req_tag,
    output logic                req_ready,
    input  logic [3:0]          ways_cfg,
    input  logic                pop,
    output logic                empty,
    output salru_pkg::result_t  res
);
    import salru_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;

    // Line memory, one row per set
    logic [MAX_WAYS-1:0]       valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][63:0] tag_mem   [NUM_SETS];
    logic [MAX_WAYS-1:0][31:0] stamp_mem [NUM_SETS];
    logic [NUM_SETS-1:0]       touched_reg;

    logic [MAX_WAYS-1:0]       rd_valid_reg;
    logic [MAX_WAYS-1:0][63:0] rd_tag_reg;
    logic [MAX_WAYS-1:0][31:0] rd_stamp_reg;
    logic                      rd_touched_reg;

    logic [1:0]       state_reg, state_next;
    logic [SET_W-1:0] set_reg;
    logic [63:0]      tag_reg;
    logic             twice_reg;
    logic [31:0]      clock_reg, hits_reg, misses_reg, evict_reg;

    result_t          out_q_reg [2];
    logic [1:0]       out_count_reg;
    logic             out_head_reg, out_tail_reg;
    logic             out_space, out_push, out_pop;

    logic             rd_en;
    logic [SET_W-1:0] rd_addr;

    logic [WCNT_W-1:0]         ways_eff;
    logic [MAX_WAYS-1:0]       in_use, row_valid, hit_vec, inv_vec, lru_vec;
    logic [MAX_WAYS-1:0][31:0] row_stamp;
    logic [WAY_W-1:0]          hit_way, inv_way, lru_way, sel_way;
    logic                      hit_any, inv_any;
    logic [31:0]               clock_new;
    logic [MAX_WAYS-1:0]       new_valid;
    logic [MAX_WAYS-1:0][63:0] new_tag;
    logic [MAX_WAYS-1:0][31:0] new_stamp;
    result_t                   res_new;
    logic                      do_eval;

    assign out_space = (out_count_reg != 2'd2);
    assign req_ready = (state_reg == S_IDLE) && out_space;
    assign do_eval   = (state_reg == S_EVAL);

    // Read address and sequencing
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = set_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_ctl.valid && out_space)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = req_set;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = twice_reg ? S_RD2 : S_IDLE;
            end
            S_RD2:
            begin
                if (out_space)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read the set row and write back the updated row
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg   <= valid_mem[rd_addr];
            rd_tag_reg     <= tag_mem[rd_addr];
            rd_stamp_reg   <= stamp_mem[rd_addr];
            rd_touched_reg <= touched_reg[rd_addr];
        end
        if (do_eval)
        begin
            valid_mem[set_reg] <= new_valid;
            tag_mem[set_reg]   <= new_tag;
            stamp_mem[set_reg] <= new_stamp;
        end
    end

    // Compare ways and pick the line
    always_comb
    begin
        if (ways_cfg == 4'd0)
            ways_eff = WCNT_W'(1);
        else if (32'(ways_cfg) > MAX_WAYS)
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(ways_cfg);

        row_valid = rd_touched_reg ? rd_valid_reg : '0;
        row_stamp = rd_touched_reg ? rd_stamp_reg : '0;

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i]  = (32'(i) < 32'(ways_eff));
            hit_vec[i] = in_use[i] && row_valid[i] && (rd_tag_reg[i] == tag_reg);
            inv_vec[i] = in_use[i] && !row_valid[i];
        end

        // Way i is LRU if strictly older than lower ways, not newer than higher
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            lru_vec[i] = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (in_use[j] && (j < i) && !(row_stamp[i] < row_stamp[j]))
                    lru_vec[i] = 1'b0;
                if (in_use[j] && (j > i) && (row_stamp[j] < row_stamp[i]))
                    lru_vec[i] = 1'b0;
            end
        end

        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_way = WAY_W'(i);
            if (inv_vec[i])
                inv_way = WAY_W'(i);
            if (lru_vec[i])
                lru_way = WAY_W'(i);
        end
        hit_any = |hit_vec;
        inv_any = |inv_vec;

        priority if (hit_any)
            sel_way = hit_way;
        else if (inv_any)
            sel_way = inv_way;
        else
            sel_way = lru_way;

        clock_new = clock_reg + 32'd1;
        new_valid = row_valid;
        new_tag   = rd_tag_reg;
        new_stamp = row_stamp;
        new_valid[sel_way] = 1'b1;
        new_stamp[sel_way] = clock_new;
        if (!hit_any)
            new_tag[sel_way] = tag_reg;

        res_new.last      = !twice_reg;
        res_new.hits      = hits_reg;
        res_new.misses    = misses_reg;
        res_new.evictions = evict_reg;
        priority if (hit_any)
        begin
            res_new.outcome = OUT_HIT;
            if (hits_reg != CNT_MAX)
                res_new.hits = hits_reg + 32'd1;
        end
        else
        begin
            res_new.outcome = inv_any ? OUT_FILL : OUT_EVICT;
            if (misses_reg != CNT_MAX)
                res_new.misses = misses_reg + 32'd1;
            if (!inv_any && (evict_reg != CNT_MAX))
                res_new.evictions = evict_reg + 32'd1;
        end
    end

    assign out_push = do_eval;
    assign out_pop  = pop && (out_count_reg != 2'd0);

    // Result queue storage and request capture
    always_ff @(posedge clk)
    begin
        if (out_push)
            out_q_reg[out_tail_reg] <= res_new;
        if (state_reg == S_IDLE && rd_en)
        begin
            set_reg <= req_set;
            tag_reg <= req_tag;
        end
    end

    // Control state, counters and clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            twice_reg     <= 1'b0;
            touched_reg   <= '0;
            clock_reg     <= 32'd0;
            hits_reg      <= 32'd0;
            misses_reg    <= 32'd0;
            evict_reg     <= 32'd0;
            out_count_reg <= 2'd0;
            out_head_reg  <= 1'b0;
            out_tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && rd_en)
                twice_reg <= req_ctl.twice;
            if (do_eval)
            begin
                twice_reg            <= 1'b0;
                touched_reg[set_reg] <= 1'b1;
                clock_reg            <= clock_new;
                hits_reg             <= res_new.hits;
                misses_reg           <= res_new.misses;
                evict_reg            <= res_new.evictions;
            end
            if (out_push)
                out_tail_reg <= ~out_tail_reg;
            if (out_pop)
                out_head_reg <= ~out_head_reg;
            if (out_push && !out_pop)
                out_count_reg <= out_count_reg + 2'd1;
            else if (!out_push && out_pop)
                out_count_reg <= out_count_reg - 2'd1;
        end
    end

    assign empty = (out_count_reg == 2'd0);
    assign res   = out_q_reg[out_head_reg];

endmodule

[design/set_assoc_cache_lru_sim.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache with LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// In the back end each access first reads the set row from the line
// memory, then compares all ways in parallel, writes the row back and
// queues the result. A modify makes two accesses, since its second access
// must re-read the row that its first access just wrote. A two-word input
// queue and a two-word result queue keep push and pop decoupled from that
// loop.
// The line memory needs no clearing pass: a per-set flag marks rows that
// were never written, and they read as all-invalid with zero stamps.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [63:0] address,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  outcome,
    output logic        last,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] eviction_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import salru_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [2:0]       set_bits_reg;
    logic [5:0]       off_bits_reg;
    logic [3:0]       ways_reg;
    req_ctl_t         req_ctl;
    logic [SET_W-1:0] req_set;
    logic [63:0]      req_tag;
    logic             req_ready;
    result_t          res;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= RST_SET_BITS;
            off_bits_reg <= RST_OFF_BITS;
            ways_reg     <= RST_WAYS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_data[2:0];
                CFG_OFF_BITS: off_bits_reg <= cfg_data;
                CFG_WAYS:     ways_reg     <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    salru_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .SET_W        (SET_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .address   (address),
        .set_bits  (set_bits_reg),
        .off_bits  (off_bits_reg),
        .req_ctl   (req_ctl),
        .req_set   (req_set),
        .req_tag   (req_tag),
        .req_ready (req_ready)
    );

    salru_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .SET_W        (SET_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ctl   (req_ctl),
        .req_set   (req_set),
        .req_tag   (req_tag),
        .req_ready (req_ready),
        .ways_cfg  (ways_reg),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign outcome        = res.outcome;
    assign last           = res.last;
    assign hit_total      = res.hits;
    assign miss_total     = res.misses;
    assign eviction_total = res.evictions;

`ifndef ASSERT_OFF
    // A waiting result only carries a defined outcome code
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((outcome == OUT_HIT) || (outcome == OUT_FILL) ||
                    (outcome == OUT_EVICT)))
        else $error("result outcome code out of range");

    // Evictions are a subset of misses
    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (eviction_total <= miss_total))
        else $error("eviction total exceeds miss total");
`endif

endmodule
